[rtl/ubx_frame_builder_macros.svh]
// Assertion helpers used by the frame builder's back end (ubx_back).
`ifndef UBX_FRAME_BUILDER_MACROS_SVH
`define UBX_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define UBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define UBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ubx_pkg.sv]
`default_nettype none

package ubx_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_len;

    localparam t_byte SYNC_FIRST  = 8'hB5;
    localparam t_byte SYNC_SECOND = 8'h62;

    // command queue between front and back
    localparam int unsigned UBX_QDEPTH = 4;
    localparam int unsigned UBX_QAW    = $clog2(UBX_QDEPTH);

    typedef enum logic {
        MODE_HDR = 1'b0,
        MODE_PAY = 1'b1
    } t_mode;

    // one classified item; data is class for a header, the byte for payload
    typedef struct packed {
        t_mode kind;
        t_byte data;
        t_byte msg_id;
        t_len  len;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [7:0] {
        ST_START = 8'b0000_0001,
        ST_SYNC2 = 8'b0000_0010,
        ST_CLASS = 8'b0000_0100,
        ST_ID    = 8'b0000_1000,
        ST_LENLO = 8'b0001_0000,
        ST_LENHI = 8'b0010_0000,
        ST_CKA   = 8'b0100_0000,
        ST_CKB   = 8'b1000_0000
    } t_bstate;

endpackage

`default_nettype wire

[rtl/ubx_if.sv]
`default_nettype none

interface ubx_in_if import ubx_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  mode;
    t_byte hdr_class;
    t_byte msg_id;
    t_len  body_len;
    t_byte payload_byte;

    modport source (output valid, mode, hdr_class, msg_id, body_len, payload_byte,
                    input ready);
    modport sink   (input valid, mode, hdr_class, msg_id, body_len, payload_byte,
                    output ready);
endinterface

interface ubx_out_if import ubx_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  run_last;
    logic  frame_end;

    modport source (output valid, out_byte, run_last, frame_end, input ready);
    modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

`default_nettype wire

[rtl/ubx_frame_builder.sv]
// Frame builder for binary receiver command frames with an 8-bit Fletcher
// checksum. A header beat (mode 0) produces sync 0xB5, sync 0x62, class, id,
// length low, length high; each payload beat (mode 1) produces its byte, and
// the frame's last payload byte is followed by checksum A and checksum B
// (frame_end set on B). A zero-length header gets both checksum bytes right
// after it. Payload beats with no frame open are taken and dropped; a new
// header abandons an unfinished frame. run_last marks the final output beat
// of each input beat. Output rate is one byte per cycle while the receiver
// holds ready and the queue is not empty, set by the single output register
// of the byte sequencer. The input side runs ahead through a 4-entry command
// queue, so input accepts one beat per cycle until the queue fills. An input
// beat passes through the command queue and then the output register before
// its first byte appears. Reset is synchronous, active low.
`default_nettype none

module ubx_frame_builder import ubx_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ubx_in_if.sink    i_in,
    ubx_out_if.source o_out
);

    logic      push;
    t_cmd      push_cmd;
    logic      pop;
    t_cmd      head;
    t_q_status q_status;

    // front: accepts beats, tracks frame state, drops stray payload
    ubx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // decouples front from the byte sequencer
    ubx_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // back: walks each command out byte by byte and runs the checksum
    ubx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

[rtl/ubx_front.sv]
`default_nettype none

module ubx_front import ubx_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    ubx_in_if.sink         i_in,
    input  wire t_q_status i_q_status,
    output logic           o_push,
    output t_cmd           o_cmd
);

    logic r_open, n_open;
    t_len r_left, n_left;
    logic accept;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        n_open = r_open;
        n_left = r_left;
        if (accept) begin
            if (t_mode'(i_in.mode) == MODE_HDR) begin
                o_push       = 1'b1;
                o_cmd.kind   = MODE_HDR;
                o_cmd.data   = i_in.hdr_class;
                o_cmd.msg_id = i_in.msg_id;
                o_cmd.len    = i_in.body_len;
                o_cmd.last   = (i_in.body_len == '0);
                n_open       = (i_in.body_len != '0);
                n_left       = i_in.body_len;
            end else if (r_open) begin
                // open frame always has at least one byte left
                o_push     = 1'b1;
                o_cmd.kind = MODE_PAY;
                o_cmd.data = i_in.payload_byte;
                o_cmd.last = (r_left == t_len'(1));
                n_left     = r_left - t_len'(1);
                n_open     = (r_left != t_len'(1));
            end
            // payload with no frame open: taken and dropped
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

[rtl/ubx_cmd_fifo.sv]
`default_nettype none

module ubx_cmd_fifo import ubx_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_head,
    output t_q_status  o_status
);

    t_cmd               r_mem [UBX_QDEPTH];
    logic [UBX_QAW-1:0] r_wr;
    logic [UBX_QAW-1:0] r_rd;
    logic [UBX_QAW:0]   r_cnt;
    logic               do_wr;
    logic               do_rd;

    assign o_status.full  = (r_cnt == UBX_QAW'(0) + (UBX_QAW+1)'(UBX_QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_wr  = i_push && !o_status.full;
    assign do_rd  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= r_wr + UBX_QAW'(1);
            end
            if (do_rd) begin
                r_rd <= r_rd + UBX_QAW'(1);
            end
            r_cnt <= r_cnt + (UBX_QAW+1)'(do_wr) - (UBX_QAW+1)'(do_rd);
        end
    end

endmodule

`default_nettype wire

[rtl/ubx_back.sv]
`default_nettype none

`include "ubx_frame_builder_macros.svh"

module ubx_back import ubx_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_head,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    ubx_out_if.source      o_out
);

    t_bstate r_state, n_state;
    t_byte   r_sum_a, n_sum_a;
    t_byte   r_sum_b, n_sum_b;
    t_byte   r_out_byte;
    logic    r_out_valid;
    logic    r_out_last;
    logic    r_out_end;

    logic    adv;
    logic    emit;
    t_byte   byte_nx;
    logic    fin;
    logic    is_end;
    logic    do_acc;
    logic    do_clr;
    t_byte   acc_a;

    assign adv  = !r_out_valid || o_out.ready;
    assign emit = !i_q_status.empty && adv;

    always_comb begin
        n_state = r_state;
        byte_nx = '0;
        fin     = 1'b0;
        is_end  = 1'b0;
        do_acc  = 1'b0;
        do_clr  = 1'b0;
        unique case (r_state)
            ST_START: begin
                if (i_head.kind == MODE_HDR) begin
                    byte_nx = SYNC_FIRST;
                    do_clr  = 1'b1;
                    n_state = ST_SYNC2;
                end else begin
                    byte_nx = i_head.data;
                    do_acc  = 1'b1;
                    if (i_head.last) begin
                        n_state = ST_CKA;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            ST_SYNC2: begin
                byte_nx = SYNC_SECOND;
                n_state = ST_CLASS;
            end
            ST_CLASS: begin
                byte_nx = i_head.data;
                do_acc  = 1'b1;
                n_state = ST_ID;
            end
            ST_ID: begin
                byte_nx = i_head.msg_id;
                do_acc  = 1'b1;
                n_state = ST_LENLO;
            end
            ST_LENLO: begin
                byte_nx = i_head.len[7:0];
                do_acc  = 1'b1;
                n_state = ST_LENHI;
            end
            ST_LENHI: begin
                byte_nx = i_head.len[15:8];
                do_acc  = 1'b1;
                if (i_head.last) begin
                    n_state = ST_CKA;
                end else begin
                    fin     = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_CKA: begin
                byte_nx = r_sum_a;
                n_state = ST_CKB;
            end
            ST_CKB: begin
                byte_nx = r_sum_b;
                is_end  = 1'b1;
                fin     = 1'b1;
                n_state = ST_START;
            end
            default: begin
                n_state = ST_START;
            end
        endcase
    end

    // Fletcher step, both 8-bit sums modulo 256
    assign acc_a = r_sum_a + byte_nx;

    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (do_clr) begin
            n_sum_a = '0;
            n_sum_b = '0;
        end else if (do_acc) begin
            n_sum_a = acc_a;
            n_sum_b = r_sum_b + acc_a;
        end
    end

    assign o_pop = emit && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_state <= n_state;
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
            end
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_nx;
            r_out_last <= fin;
            r_out_end  <= is_end;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.run_last  = r_out_last;
    assign o_out.frame_end = r_out_end;

    `UBX_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, r_out_valid && r_out_end, r_out_last, "frame end beat not marked last")
    `UBX_ASSERT_NXT(a_hdr_clears_sums, i_clk, i_rst_n, emit && r_state == ST_START && i_head.kind == MODE_HDR, r_sum_a == '0 && r_sum_b == '0, "sums not cleared at header")
    `UBX_ASSERT_NXT(a_cka_is_sum, i_clk, i_rst_n, emit && r_state == ST_CKA, r_out_byte == $past(r_sum_a) && !r_out_last, "checksum A beat wrong")

endmodule

`default_nettype wire

[sim/ubx_frame_checker.sv]
`default_nettype none

// Watches both channels of the frame builder, works out the framed bytes that
// every accepted input beat must produce, and compares them in order.
module ubx_frame_checker import ubx_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ubx_in_if         i_in,
    ubx_out_if        i_out,
    output int        o_mismatches,
    output int        o_pending
);

    typedef struct packed {
        t_byte data;
        logic  last;
        logic  fend;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    t_byte ck_a;
    t_byte ck_b;
    t_len  bytes_left;
    logic  in_frame;
    int    mismatches;

    task automatic fold_byte(input t_byte b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endtask

    task automatic predict_frame_bytes(input t_mode mode, input t_byte cls, input t_byte id,
                                       input t_len len, input t_byte pay);
        frame_beat_t beats[$];
        t_byte       hdr[4];
        if (mode == MODE_HDR) begin
            hdr = '{cls, id, len[7:0], len[15:8]};
            ck_a = '0;
            ck_b = '0;
            beats.push_back('{SYNC_FIRST, 1'b0, 1'b0});
            beats.push_back('{SYNC_SECOND, 1'b0, 1'b0});
            foreach (hdr[i]) begin
                beats.push_back('{hdr[i], 1'b0, 1'b0});
                fold_byte(hdr[i]);
            end
            bytes_left = len;
            in_frame   = 1'b1;
        end else if (in_frame) begin
            beats.push_back('{pay, 1'b0, 1'b0});
            fold_byte(pay);
            bytes_left = bytes_left - 1'b1;
        end
        // frame complete: checksum A, then checksum B closes it
        if (in_frame && bytes_left == '0) begin
            beats.push_back('{ck_a, 1'b0, 1'b0});
            beats.push_back('{ck_b, 1'b0, 1'b1});
            in_frame = 1'b0;
        end
        if (beats.size() != 0) begin
            beats[beats.size() - 1].last = 1'b1;
        end
        foreach (beats[i]) begin
            expected_beats.push_back(beats[i]);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        frame_beat_t want;
        if (!i_rst_n) begin
            ck_a       = '0;
            ck_b       = '0;
            bytes_left = '0;
            in_frame   = 1'b0;
            mismatches = 0;
            expected_beats.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                predict_frame_bytes(t_mode'(i_in.mode), i_in.hdr_class, i_in.msg_id,
                                    i_in.body_len, i_in.payload_byte);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected output beat: expected none, got byte %02h", $time,
                             i_out.out_byte);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("out_byte", want.data, i_out.out_byte);
                    check_field("run_last", want.last, i_out.run_last);
                    check_field("frame_end", want.fend, i_out.frame_end);
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_beats.size();
    end

endmodule

`default_nettype wire

[sim/ubx_frame_builder_test.sv]
`default_nettype none

// Top of the frame builder testbench: clock, reset, input beats, output
// back-pressure and the verdict. All checking lives in ubx_frame_checker.
module ubx_frame_builder_test;
    import ubx_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 120;
    localparam int unsigned IDLE_LIMIT   = 1000;  // cycles with no beat on either side
    localparam int unsigned SQUEEZE_LEN  = 160;   // long output hold-off
    localparam int unsigned TAIL_CYCLES  = 20;

    logic i_clk;
    logic i_rst_n;

    ubx_in_if  in_ch();
    ubx_out_if out_ch();

    int mismatches;
    int pending;

    ubx_frame_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ubx_frame_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Sender side state
    // ---------------------------------------------------------------------
    bit          tx_calm;      // back-to-back beats while set
    bit          squeeze_req;  // asks the receiver for its long hold-off
    logic        gen_open;     // frame tracking, only used to count live beats
    t_len        gen_left;
    int unsigned live_items;   // beats that the block does not just drop

    // ---------------------------------------------------------------------
    // Receiver side: one ready decision per falling edge
    // ---------------------------------------------------------------------
    bit          rx_calm;
    bit          beat_taken;
    bit          squeeze_done;
    int unsigned rx_wait;
    int unsigned hold_cnt;

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_HDR;
        in_ch.hdr_class    = '0;
        in_ch.msg_id       = '0;
        in_ch.body_len     = '0;
        in_ch.payload_byte = '0;
        out_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        tx_calm            = 1'b0;
        squeeze_req        = 1'b0;
        gen_open           = 1'b0;
        gen_left           = '0;
        live_items         = 0;
        rx_calm            = 1'b0;
        beat_taken         = 1'b0;
        squeeze_done       = 1'b0;
        rx_wait            = 0;
        hold_cnt           = 0;
    end

    // note a beat taken at the rising edge, so the next falling edge can
    // draw a fresh stall for the following one
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            beat_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (squeeze_req && !squeeze_done) begin
            // long hold-off: the command queue fills and input ready drops
            hold_cnt     = SQUEEZE_LEN;
            squeeze_done = 1'b1;
        end
        if (beat_taken) begin
            beat_taken = 1'b0;
            rx_wait    = rx_calm ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0) begin
                rx_calm = !rx_calm;
            end
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= i_rst_n;
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too long without any beat on either channel ends the run
    // ---------------------------------------------------------------------
    int unsigned idle_cnt;

    initial idle_cnt = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Input beats
    // ---------------------------------------------------------------------

    // Offer one beat after a random gap and hold it until it is taken.
    // valid stays high across back-to-back beats: only one assignment per edge.
    task automatic send_item(input t_mode mode, input t_byte cls, input t_byte id,
                             input t_len len, input t_byte pay);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.hdr_class    <= cls;
        in_ch.msg_id       <= id;
        in_ch.body_len     <= len;
        in_ch.payload_byte <= pay;
        do @(posedge i_clk); while (!in_ch.ready);
        // count everything but payload beats with no frame open
        if (mode == MODE_HDR) begin
            live_items++;
            gen_open = (len != '0);
            gen_left = len;
        end else if (gen_open) begin
            live_items++;
            gen_left = gen_left - 1'b1;
            gen_open = (gen_left != '0);
        end
    endtask

    // ignored fields always carry random junk
    task automatic send_header(input t_byte cls, input t_byte id, input t_len len);
        send_item(MODE_HDR, cls, id, len, t_byte'($urandom));
    endtask

    task automatic send_payload(input t_byte b);
        send_item(MODE_PAY, t_byte'($urandom), t_byte'($urandom), t_len'($urandom), b);
    endtask

    // header with random class and id, then `count` random payload bytes;
    // count below len leaves the frame open
    task automatic send_frame(input t_len len, input int unsigned count);
        send_header(t_byte'($urandom), t_byte'($urandom), len);
        repeat (count) send_payload(t_byte'($urandom));
    endtask

    initial begin
        int unsigned pick;
        int unsigned round;
        int unsigned cut;
        t_len        len;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        send_payload(8'hFF);                  // no frame open yet: dropped
        send_header(8'h00, 8'h00, 16'h0000);  // empty payload, checksum right away
        send_header(8'hFF, 8'hFF, 16'h0001);  // sums wrap hard
        send_payload(8'hFF);
        send_header(8'h06, 8'h01, 16'h0002);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);                  // frame just closed: dropped
        send_header(8'hA5, 8'h5A, 16'hFFFF);  // left open ...
        send_payload(8'h12);
        send_header(8'h06, 8'h04, 16'h0100);  // ... abandoned by a new header
        send_payload(8'h01);
        send_payload(8'h80);
        send_payload(8'h7F);
        send_header(8'h0A, 8'h04, 16'h0000);  // abandons again, empty frame
        send_payload(8'h33);                  // dropped
        send_header(8'h55, 8'hAA, 16'h0003);
        send_payload(8'hAA);
        send_payload(8'h55);
        send_payload(8'hC3);

        // ---- random ----
        round = 0;
        while (live_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                tx_calm = !tx_calm;
            end
            pick = $urandom_range(0, 9);
            if (round == 4) begin
                // back-to-back frame against the long output hold-off
                squeeze_req = 1'b1;
                tx_calm     = 1'b1;
                send_frame(16'd20, 20);
                tx_calm     = 1'b0;
            end else if (pick <= 6) begin
                // well-formed frame, mostly short
                len = ($urandom_range(0, 7) == 0) ? t_len'($urandom_range(7, 24))
                                                  : t_len'($urandom_range(0, 6));
                send_frame(len, len);
            end else if (pick == 7) begin
                // any length, cut short: stays open until the next header
                len = t_len'($urandom_range(1, 16'hFFFF));
                cut = $urandom_range(0, (len > 3) ? 3 : len - 1);
                send_frame(len, cut);
            end else begin
                // stray payload, or one more byte of an open frame
                send_payload(t_byte'($urandom));
            end
            round++;
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // drain; the watchdog covers a hang here
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
